// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
// Each macro expands to one labeled concurrent assertion on clk_i, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`endif

// ----- rtl/u8m_pkg.sv -----
// ----------------------------------------------------------------------------
// u8m_pkg: shared types and constants of the UTF-8 music text folder
// Item types for both channels, the group state, and the folding tables.
// ----------------------------------------------------------------------------
package u8m_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       char_valid;
    logic       run_last;
    logic       text_end;
  } out_item_t;

  // Open group state. Only entries below held_count are ever read.
  typedef struct packed {
    logic [7:0] held0;
    logic [7:0] held1;
    logic [7:0] held2;
    logic [1:0] held_count;
    logic [2:0] group_length;
  } grp_state_t;

  // Characters produced by one byte, at most two.
  typedef struct packed {
    logic [6:0] char0;
    logic [6:0] char1;
    logic [1:0] num;
    logic       fin;
  } fold_res_t;

  localparam logic [7:0] BYTE_LATIN_LEAD = 8'hC3;
  localparam logic [7:0] BYTE_SYM_LEAD   = 8'hE2;
  localparam logic [7:0] BYTE_SYM_MID    = 8'h99;
  localparam logic [7:0] BYTE_SHARP      = 8'hAF;
  localparam logic [7:0] BYTE_FLAT       = 8'hAD;
  localparam logic [7:0] BYTE_MUS_LEAD   = 8'hF0;
  localparam logic [7:0] BYTE_MUS_2      = 8'h9D;
  localparam logic [7:0] BYTE_MUS_3      = 8'h84;
  localparam logic [7:0] BYTE_DSHARP     = 8'hAA;
  localparam logic [7:0] BYTE_DFLAT      = 8'hAB;

  localparam logic [6:0] CHAR_NONE  = 7'h00;
  localparam logic [6:0] CHAR_HASH  = 7'h23;
  localparam logic [6:0] CHAR_B     = 7'h62;
  localparam logic [6:0] CHAR_E     = 7'h65;
  localparam logic [6:0] CHAR_A     = 7'h61;
  localparam logic [6:0] CHAR_U     = 7'h75;
  localparam logic [6:0] CHAR_I     = 7'h69;
  localparam logic [6:0] CHAR_O     = 7'h6F;
  localparam logic [6:0] CHAR_C_UP  = 7'h43;
  localparam logic [6:0] CHAR_C     = 7'h63;

  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_TWO  = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR = 3'd4;

  // Group length announced by a lead byte, zero for any other byte.
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = LEN_NONE;
    if ((b & 8'hE0) == 8'hC0) begin
      len = LEN_TWO;
    end else if ((b & 8'hF0) == 8'hE0) begin
      len = LEN_THREE;
    end else if ((b & 8'hF8) == 8'hF0) begin
      len = LEN_FOUR;
    end
    return len;
  endfunction

  // Plain letter for the second byte of a C3 group, zero when unlisted.
  function automatic logic [6:0] fold_latin(input logic [7:0] c2);
    logic [6:0] c;
    case (c2)
      8'hA8, 8'hA9, 8'hAA, 8'hAB: c = CHAR_E;
      8'hA0, 8'hA2, 8'hA4:        c = CHAR_A;
      8'hB9, 8'hBB, 8'hBC:        c = CHAR_U;
      8'hAE, 8'hAF:               c = CHAR_I;
      8'hB4, 8'hB6:               c = CHAR_O;
      8'h87:                      c = CHAR_C_UP;
      8'hA7:                      c = CHAR_C;
      default:                    c = CHAR_NONE;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/u8m_fold.sv -----
// ----------------------------------------------------------------------------
// u8m_fold: one-byte folding step
// Combines the open group with a new byte and gives the next group state
// and the zero to two characters that the byte causes.
// ----------------------------------------------------------------------------
module u8m_fold import u8m_pkg::*; (
  input  grp_state_t st_i,
  input  in_item_t   item_i,
  output grp_state_t st_o,
  output fold_res_t  res_o
);

  logic [7:0] b;
  logic       fin;
  logic       open;
  logic [2:0] total;
  logic [7:0] buf1;
  logic [7:0] buf2;
  logic [6:0] lat;
  logic [6:0] tail_lat;
  logic [6:0] c0;
  logic [6:0] c1;
  logic [1:0] n;

  assign b     = item_i.in_byte;
  assign fin   = item_i.final_byte;
  assign open  = (st_i.group_length != LEN_NONE) && (st_i.held_count != 2'd0);
  assign total = {1'b0, st_i.held_count} + 3'd1;
  assign buf1  = (st_i.held_count == 2'd1) ? b : st_i.held1;
  assign buf2  = (st_i.held_count == 2'd2) ? b : st_i.held2;
  assign lat      = fold_latin(buf1);
  assign tail_lat = fold_latin(b);

  always_comb begin
    st_o = st_i;
    c0   = CHAR_NONE;
    c1   = CHAR_NONE;
    n    = 2'd0;
    if (open) begin
      if (total == st_i.group_length) begin
        // The group is complete: fold it and close it.
        st_o.held_count   = 2'd0;
        st_o.group_length = LEN_NONE;
        case (st_i.group_length)
          LEN_TWO: begin
            if (st_i.held0 == BYTE_LATIN_LEAD && lat != CHAR_NONE) begin
              c0 = lat;
              n  = 2'd1;
            end
          end
          LEN_THREE: begin
            if (st_i.held0 == BYTE_SYM_LEAD && buf1 == BYTE_SYM_MID) begin
              if (b == BYTE_SHARP) begin
                c0 = CHAR_HASH;
                n  = 2'd1;
              end else if (b == BYTE_FLAT) begin
                c0 = CHAR_B;
                n  = 2'd1;
              end
            end
          end
          LEN_FOUR: begin
            if (st_i.held0 == BYTE_MUS_LEAD && buf1 == BYTE_MUS_2 && buf2 == BYTE_MUS_3) begin
              if (b == BYTE_DSHARP) begin
                c0 = CHAR_HASH;
                c1 = CHAR_HASH;
                n  = 2'd2;
              end else if (b == BYTE_DFLAT) begin
                c0 = CHAR_B;
                c1 = CHAR_B;
                n  = 2'd2;
              end
            end
          end
          default: begin
            n = 2'd0;
          end
        endcase
      end else if (fin) begin
        // Text ends inside the group: drop the lead byte and rescan the rest.
        if (st_i.held_count == 2'd2) begin
          if (!st_i.held1[7]) begin
            c0 = st_i.held1[6:0];
            if (!b[7]) begin
              c1 = b[6:0];
              n  = 2'd2;
            end else begin
              n  = 2'd1;
            end
          end else if (lead_len(st_i.held1) == LEN_TWO) begin
            if (st_i.held1 == BYTE_LATIN_LEAD && tail_lat != CHAR_NONE) begin
              c0 = tail_lat;
              n  = 2'd1;
            end
          end else if (!b[7]) begin
            c0 = b[6:0];
            n  = 2'd1;
          end
        end else if (!b[7]) begin
          c0 = b[6:0];
          n  = 2'd1;
        end
      end else begin
        // Group still open: hold the byte.
        if (st_i.held_count == 2'd1) begin
          st_o.held1 = b;
        end else begin
          st_o.held2 = b;
        end
        st_o.held_count = st_i.held_count + 2'd1;
      end
    end else begin
      st_o.held_count   = 2'd0;
      st_o.group_length = LEN_NONE;
      if (!b[7]) begin
        c0 = b[6:0];
        n  = 2'd1;
      end else if (lead_len(b) != LEN_NONE && !fin) begin
        st_o.held0        = b;
        st_o.held_count   = 2'd1;
        st_o.group_length = lead_len(b);
      end
    end
    if (fin) begin
      st_o.held_count   = 2'd0;
      st_o.group_length = LEN_NONE;
    end
  end

  assign res_o = '{char0: c0, char1: c1, num: n, fin: fin};

endmodule

// ----- rtl/utf8_music_text_to_ascii_top.sv -----
// ----------------------------------------------------------------------------
// utf8_music_text_to_ascii_top: UTF-8 music text to ASCII folder
// Takes UTF-8 text a byte at a time and emits plain ASCII characters, with
// accidentals and accented Latin letters folded to ASCII.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid_i / in_stall_o   in_item_i  (in_item_t)
//   out      output     out_valid_o / out_stall_i out_item_o (out_item_t)
//
// The block takes one byte per cycle while in_stall_o is low. A byte that gives
// two characters holds the result register until both have left, so the next
// byte waits in the input register there. A byte passes through the input
// register and then the result register before its result can leave. Reset
// clears the group state and all valid flags; nothing else is needed before the
// first byte. A stalled output keeps its item, and the input register still
// takes one more byte while the output waits.
//
module utf8_music_text_to_ascii_top import u8m_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

`include "assert_macros.svh"

  // Input register: one byte, parted from the result register so that the
  // input keeps flowing while a result waits.
  logic      in_v_q;
  in_item_t  in_q;

  // Group state, updated when a byte moves from the input register on.
  grp_state_t st_q;
  grp_state_t st_d;
  fold_res_t  res;

  // Result register: up to two items, res0_q is the one shown.
  logic      v0_q;
  logic      v1_q;
  out_item_t res0_q;
  out_item_t res1_q;
  out_item_t item0;
  out_item_t item1;

  logic accept;
  logic take;
  logic move;
  logic emit;

  u8m_fold u_fold (
    .st_i   (st_q),
    .item_i (in_q),
    .st_o   (st_d),
    .res_o  (res)
  );

  // The byte in the input register moves on when the result register is
  // empty, or when its last item leaves in this cycle.
  assign take       = v0_q && !out_stall_i;
  assign move       = in_v_q && (!v0_q || (take && !v1_q));
  assign in_stall_o = in_v_q && !move;
  assign accept     = in_valid_i && !in_stall_o;

  // A final byte with no character still sends a bare end marker.
  assign emit = (res.num != 2'd0) || res.fin;

  always_comb begin
    item0.out_char   = res.char0;
    item0.char_valid = (res.num != 2'd0);
    item0.run_last   = (res.num != 2'd2);
    item0.text_end   = res.fin && (res.num != 2'd2);
    item1.out_char   = res.char1;
    item1.char_valid = 1'b1;
    item1.run_last   = 1'b1;
    item1.text_end   = res.fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (accept) begin
      in_v_q <= 1'b1;
    end else if (move) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_item_i;
    end
  end

  // Group state. The held bytes are cleared as well, although only entries
  // below held_count are ever read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (move) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (move) begin
      v0_q <= emit;
      v1_q <= (res.num == 2'd2);
    end else if (take) begin
      if (v1_q) begin
        v1_q <= 1'b0;
      end else begin
        v0_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      res0_q <= item0;
      res1_q <= item1;
    end else if (take && v1_q) begin
      res0_q <= res1_q;
    end
  end

  assign out_valid_o = v0_q;
  assign out_item_o  = res0_q;

  // A second item never waits without a first in front of it.
  `ASSERT_SAME(a_second_behind_first, v1_q, v0_q)
  // The first of a pair is never marked as the last item of its byte.
  `ASSERT_SAME(a_pair_head_not_last, v0_q && v1_q, !res0_q.run_last)
  // A byte that gives two characters leaves both in the result register.
  `ASSERT_NEXT(a_pair_loaded, move && (res.num == 2'd2), v0_q && v1_q)
  // An open group always holds fewer bytes than its length.
  `ASSERT_SAME(a_group_count, st_q.group_length != LEN_NONE,
               (st_q.held_count != 2'd0) &&
               ({1'b0, st_q.held_count} < st_q.group_length))

endmodule
